[src/bpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator: sizes, codes,
// sequencer state, datapath commands and status.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGE_COUNT = 65536;
  localparam int unsigned TOP_ORDER  = 10;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam int unsigned NUM_ORD = TOP_ORDER + 1;
  localparam int unsigned PFN_W   = $clog2(PAGE_COUNT);
  localparam int unsigned LINK_W  = PFN_W + 1;
  localparam int unsigned ORD_W   = 4;
  localparam int unsigned ADDR_W  = 33;
  localparam int unsigned BASE_W  = 32;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned MARK_W  = 2;
  localparam int unsigned RNG_W   = 17;

  localparam logic [LINK_W-1:0] NIL       = LINK_W'(PAGE_COUNT);
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [ORD_W-1:0]  ORD_TOP   = ORD_W'(TOP_ORDER);

  localparam logic [MARK_W-1:0] MARK_FREE = 2'b01;
  localparam logic [MARK_W-1:0] MARK_RESV = 2'b10;

  localparam logic [BASE_W-1:0] BASE_RESET    = 32'h0010_0000;
  localparam logic [CNT_W-1:0]  MANAGED_RESET = 17'd16384;

  localparam logic CFG_BASE    = 1'b0;
  localparam logic CFG_MANAGED = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_RESV  = 2'd2,
    ACT_REL   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    RES_DONE    = 2'd0,
    RES_OOM     = 2'd1,
    RES_INVALID = 2'd2
  } res_e;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DISP,
    ST_A_SPLIT, ST_A_SPLIT_W, ST_A_SPLIT_HI, ST_A_POP_W,
    ST_F_CHK,
    ST_M_TOP, ST_M_CHK,
    ST_RM_HEAD, ST_RM_HW, ST_RM_WALK, ST_RM_WW, ST_RM_FW, ST_RM_END,
    ST_M_HI, ST_M_HW, ST_M_LO, ST_M_LW, ST_M_RET,
    ST_R_LOOP, ST_R_W,
    ST_FIN
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_REJECT, OP_OOM,
    OP_A_FIND, OP_A_SPLIT_RD, OP_A_SPLIT_LO, OP_A_SPLIT_HI, OP_A_POP_RD, OP_A_POP_WR,
    OP_F_RD, OP_F_PUSH,
    OP_M_RD, OP_RM_SELF, OP_RM_MATE, OP_RM_HRD, OP_RM_HWR, OP_RM_WRD, OP_RM_STEP,
    OP_RM_FRD, OP_RM_FWR,
    OP_M_HRD, OP_M_HWR, OP_M_LRD, OP_M_LWR,
    OP_R_RD, OP_R_RESV, OP_R_SKIP, OP_R_PUSH,
    OP_FIN
  } op_e;

  typedef struct packed {
    act_e act;
    logic ord_bad;
    logic alloc_none;
    logic free_bad;
    logic rng_bad;
    logic split_done;
    logic mark_free;
    logic mark_resv;
    logic mate_match;
    logic top;
    logic wk_nil;
    logic wk_hit;
    logic link_hit;
    logic steps_max;
    logic rng_end;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

[src/bpa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/bpa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath
// List heads, page stores, counters, configuration and result register.
// Executes one command from the sequencer per cycle.
// ----------------------------------------------------------------------------
module bpa_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [bpa_pkg::BASE_W-1:0]   cfg_wdata_i,
  input  logic [1:0]                   action_i,
  input  logic [bpa_pkg::ORD_W-1:0]    block_order_i,
  input  logic [bpa_pkg::ADDR_W-1:0]   address_i,
  input  logic [bpa_pkg::RNG_W-1:0]    first_page_i,
  input  logic [bpa_pkg::RNG_W-1:0]    end_page_i,
  input  bpa_pkg::op_e                 op_i,
  output bpa_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [bpa_pkg::ADDR_W-1:0]   block_address_o,
  output logic [bpa_pkg::CNT_W-1:0]    used_pages_o,
  output logic [bpa_pkg::CNT_W-1:0]    total_pages_o
);
  import bpa_pkg::*;

  logic [LINK_W-1:0] heads_q [NUM_ORD];
  logic [LINK_W-1:0] heads_d [NUM_ORD];

  logic [BASE_W-1:0] base_q;
  logic [CNT_W-1:0]  managed_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  tot_q, tot_d;
  logic [PFN_W-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  act_e              act_q, act_d;
  logic [ORD_W-1:0]  ord_q, ord_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [RNG_W-1:0]  rng_q, rng_d;
  logic [RNG_W-1:0]  last_q, last_d;
  logic [ORD_W-1:0]  cur_q, cur_d;
  logic [PFN_W-1:0]  blk_q, blk_d;
  logic [PFN_W-1:0]  mate_q, mate_d;
  logic [ORD_W-1:0]  mord_q, mord_d;
  logic [LINK_W-1:0] wk_q, wk_d;
  logic [PFN_W-1:0]  rx_q, rx_d;
  logic [RNG_W-1:0]  steps_q, steps_d;
  res_e              res_q, res_d;
  logic [ADDR_W-1:0] raddr_q, raddr_d;

  logic [1:0]        out_st_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [CNT_W-1:0]  out_used_q, out_tot_q;

  logic              link_we, mark_we, ordm_we;
  logic [PFN_W-1:0]  link_wa, mark_wa, ordm_wa;
  logic [PFN_W-1:0]  link_ra, mark_ra, ordm_ra;
  logic [LINK_W-1:0] link_wd, link_rd;
  logic [MARK_W-1:0] mark_wd, mark_rd;
  logic [ORD_W-1:0]  ordm_wd, ordm_rd;

  logic [ADDR_W-1:0] diff;
  logic [PFN_W-1:0]  pfn_c;
  logic [ORD_W-1:0]  fnd;
  logic              any;
  logic [ORD_W-1:0]  half, mup;
  logic [LINK_W-1:0] upper;
  logic [PFN_W-1:0]  mate_c, high, low;
  logic [CNT_W:0]    add_sum;
  logic [CNT_W-1:0]  sub_n;

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_rd)
  );

  bpa_ram #(.WIDTH(MARK_W), .DEPTH(PAGE_COUNT)) u_mark_ram (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(mark_ra), .rdata_o(mark_rd)
  );

  bpa_ram #(.WIDTH(ORD_W), .DEPTH(PAGE_COUNT)) u_ord_ram (
    .clk_i, .we_i(ordm_we), .waddr_i(ordm_wa), .wdata_i(ordm_wd),
    .raddr_i(ordm_ra), .rdata_o(ordm_rd)
  );

  always_comb begin
    diff  = addr_q - ADDR_W'(base_q);
    pfn_c = diff[PAGE_SHIFT+PFN_W-1:PAGE_SHIFT];
    fnd   = '0;
    any   = 1'b0;
    for (int i = 0; i < NUM_ORD; i++) begin
      if (!any && ORD_W'(i) >= ord_q && !heads_q[i][PFN_W]) begin
        any = 1'b1;
        fnd = ORD_W'(i);
      end
    end
    half    = cur_q - 1'b1;
    mup     = mord_q + 1'b1;
    upper   = LINK_W'(blk_q) + (LINK_W'(1) << half);
    mate_c  = blk_q ^ (PFN_W'(1) << mord_q);
    high    = (blk_q < mate_q) ? mate_q : blk_q;
    low     = (blk_q < mate_q) ? blk_q : mate_q;
    add_sum = (CNT_W+1)'(used_q) + ((CNT_W+1)'(1) << ord_q);
    sub_n   = CNT_W'(1) << ord_q;
  end

  always_comb begin
    sts_o.act        = act_q;
    sts_o.ord_bad    = ord_q > ORD_TOP;
    sts_o.alloc_none = !any;
    sts_o.free_bad   = (addr_q == '0) || (addr_q < ADDR_W'(base_q))
                       || (diff[ADDR_W-1:PAGE_SHIFT+PFN_W] != '0)
                       || (CNT_W'(pfn_c) >= managed_q);
    sts_o.rng_bad    = rng_q[PFN_W];
    sts_o.split_done = cur_q == ord_q;
    sts_o.mark_free  = |(mark_rd & MARK_FREE);
    sts_o.mark_resv  = |(mark_rd & MARK_RESV);
    sts_o.mate_match = ordm_rd == mord_q;
    sts_o.top        = mord_q >= ORD_TOP;
    sts_o.wk_nil     = wk_q[PFN_W];
    sts_o.wk_hit     = wk_q == LINK_W'(rx_q);
    sts_o.link_hit   = link_rd == LINK_W'(rx_q);
    sts_o.steps_max  = steps_q == RNG_W'(PAGE_COUNT);
    sts_o.rng_end    = rng_q >= last_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.clr_last   = clr_q == '1;
  end

  always_comb begin
    heads_d = heads_q;
    used_d  = used_q;
    tot_d   = tot_q;
    clr_d   = clr_q;
    act_d   = act_q;
    ord_d   = ord_q;
    addr_d  = addr_q;
    rng_d   = rng_q;
    last_d  = last_q;
    cur_d   = cur_q;
    blk_d   = blk_q;
    mate_d  = mate_q;
    mord_d  = mord_q;
    wk_d    = wk_q;
    rx_d    = rx_q;
    steps_d = steps_q;
    res_d   = res_q;
    raddr_d = raddr_q;
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    link_ra = '0;
    mark_we = 1'b0;
    mark_wa = '0;
    mark_wd = '0;
    mark_ra = '0;
    ordm_we = 1'b0;
    ordm_wa = '0;
    ordm_wd = '0;
    ordm_ra = '0;
    unique case (op_i)
      OP_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      OP_LOAD: begin
        act_d   = act_e'(action_i);
        ord_d   = block_order_i;
        addr_d  = address_i;
        rng_d   = first_page_i;
        last_d  = (end_page_i > RNG_W'(PAGE_COUNT)) ? RNG_W'(PAGE_COUNT) : end_page_i;
        res_d   = RES_DONE;
        raddr_d = '0;
      end
      OP_REJECT: res_d = RES_INVALID;
      OP_OOM:    res_d = RES_OOM;
      OP_A_FIND: cur_d = fnd;
      OP_A_SPLIT_RD: begin
        blk_d   = heads_q[cur_q][PFN_W-1:0];
        link_ra = heads_q[cur_q][PFN_W-1:0];
      end
      OP_A_SPLIT_LO: begin
        heads_d[cur_q] = link_rd;
        mark_we = 1'b1;
        mark_wa = blk_q;
        mark_wd = MARK_FREE;
        ordm_we = 1'b1;
        ordm_wa = blk_q;
        ordm_wd = half;
        link_we = 1'b1;
        link_wa = blk_q;
        link_wd = heads_q[half];
        heads_d[half] = LINK_W'(blk_q);
      end
      OP_A_SPLIT_HI: begin
        if (!upper[PFN_W]) begin
          mark_we = 1'b1;
          mark_wa = upper[PFN_W-1:0];
          mark_wd = MARK_FREE;
          ordm_we = 1'b1;
          ordm_wa = upper[PFN_W-1:0];
          ordm_wd = half;
          link_we = 1'b1;
          link_wa = upper[PFN_W-1:0];
          link_wd = heads_q[half];
          heads_d[half] = upper;
        end
        cur_d = half;
      end
      OP_A_POP_RD: begin
        blk_d   = heads_q[ord_q][PFN_W-1:0];
        link_ra = heads_q[ord_q][PFN_W-1:0];
        mark_ra = heads_q[ord_q][PFN_W-1:0];
      end
      OP_A_POP_WR: begin
        heads_d[ord_q] = link_rd;
        mark_we = 1'b1;
        mark_wa = blk_q;
        mark_wd = mark_rd & ~MARK_FREE;
        ordm_we = 1'b1;
        ordm_wa = blk_q;
        ordm_wd = ord_q;
        used_d  = add_sum[CNT_W] ? COUNT_MAX : add_sum[CNT_W-1:0];
        raddr_d = ADDR_W'(base_q) + (ADDR_W'(blk_q) << PAGE_SHIFT);
      end
      OP_F_RD: begin
        blk_d   = pfn_c;
        mark_ra = pfn_c;
      end
      OP_F_PUSH: begin
        mark_we = 1'b1;
        mark_wa = blk_q;
        mark_wd = mark_rd | MARK_FREE;
        ordm_we = 1'b1;
        ordm_wa = blk_q;
        ordm_wd = ord_q;
        link_we = 1'b1;
        link_wa = blk_q;
        link_wd = heads_q[ord_q];
        heads_d[ord_q] = LINK_W'(blk_q);
        used_d  = (used_q > sub_n) ? used_q - sub_n : '0;
        mord_d  = ord_q;
      end
      OP_M_RD: begin
        mate_d  = mate_c;
        mark_ra = mate_c;
        ordm_ra = mate_c;
      end
      OP_RM_SELF: begin
        rx_d    = blk_q;
        wk_d    = heads_q[mord_q];
        steps_d = '0;
      end
      OP_RM_MATE: begin
        rx_d    = mate_q;
        wk_d    = heads_q[mord_q];
        steps_d = '0;
      end
      OP_RM_HRD: link_ra = rx_q;
      OP_RM_HWR: heads_d[mord_q] = link_rd;
      OP_RM_WRD: link_ra = wk_q[PFN_W-1:0];
      OP_RM_STEP: begin
        wk_d    = link_rd;
        steps_d = steps_q + 1'b1;
      end
      OP_RM_FRD: link_ra = rx_q;
      OP_RM_FWR: begin
        link_we = 1'b1;
        link_wa = wk_q[PFN_W-1:0];
        link_wd = link_rd;
      end
      OP_M_HRD: mark_ra = high;
      OP_M_HWR: begin
        mark_we = 1'b1;
        mark_wa = high;
        mark_wd = mark_rd & ~MARK_FREE;
      end
      OP_M_LRD: mark_ra = low;
      OP_M_LWR: begin
        mark_we = 1'b1;
        mark_wa = low;
        mark_wd = mark_rd | MARK_FREE;
        ordm_we = 1'b1;
        ordm_wa = low;
        ordm_wd = mup;
        link_we = 1'b1;
        link_wa = low;
        link_wd = heads_q[mup];
        heads_d[mup] = LINK_W'(low);
        blk_d   = low;
        mord_d  = mup;
      end
      OP_R_RD: mark_ra = rng_q[PFN_W-1:0];
      OP_R_RESV: begin
        mark_we = 1'b1;
        mark_wa = rng_q[PFN_W-1:0];
        mark_wd = mark_rd | MARK_RESV;
        rng_d   = rng_q + 1'b1;
      end
      OP_R_SKIP: rng_d = rng_q + 1'b1;
      OP_R_PUSH: begin
        mark_we = 1'b1;
        mark_wa = rng_q[PFN_W-1:0];
        mark_wd = MARK_FREE;
        ordm_we = 1'b1;
        ordm_wa = rng_q[PFN_W-1:0];
        ordm_wd = '0;
        link_we = 1'b1;
        link_wa = rng_q[PFN_W-1:0];
        link_wd = heads_q[0];
        heads_d[0] = LINK_W'(rng_q[PFN_W-1:0]);
        tot_d   = (tot_q == COUNT_MAX) ? tot_q : tot_q + 1'b1;
        blk_d   = rng_q[PFN_W-1:0];
        mord_d  = '0;
      end
      default: ;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || (op_i == OP_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ORD; i++) begin
        heads_q[i] <= NIL;
      end
      base_q      <= BASE_RESET;
      managed_q   <= MANAGED_RESET;
      used_q      <= '0;
      tot_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      heads_q     <= heads_d;
      used_q      <= used_d;
      tot_q       <= tot_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BASE:    base_q    <= cfg_wdata_i;
          CFG_MANAGED: managed_q <= cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    ord_q   <= ord_d;
    addr_q  <= addr_d;
    rng_q   <= rng_d;
    last_q  <= last_d;
    cur_q   <= cur_d;
    blk_q   <= blk_d;
    mate_q  <= mate_d;
    mord_q  <= mord_d;
    wk_q    <= wk_d;
    rx_q    <= rx_d;
    steps_q <= steps_d;
    res_q   <= res_d;
    raddr_q <= raddr_d;
    if (op_i == OP_FIN) begin
      out_st_q   <= res_q;
      out_addr_q <= raddr_q;
      out_used_q <= used_q;
      out_tot_q  <= tot_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign block_address_o = out_addr_q;
  assign used_pages_o    = out_used_q;
  assign total_pages_o   = out_tot_q;

  // result register is never overwritten before it is taken
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_FIN |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // allocation only pops a non-empty list
  a_pop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_A_POP_RD |-> !heads_q[ord_q][PFN_W])
    else $error("pop from empty list");

  // a split never starts below order one
  a_split_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_A_SPLIT_HI |-> cur_q != '0)
    else $error("split of order zero");

endmodule

[src/bpa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: clearing pass, request dispatch, split, free, merge,
// list removal walk and range walk.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::op_e  op_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  logic   second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    second_d   = second_q;
    op_o       = OP_NONE;
    in_ready_o = state_q == ST_IDLE;
    unique case (state_q)
      ST_CLR: begin
        op_o = OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.act)
          ACT_ALLOC: begin
            if (sts_i.ord_bad) begin
              op_o    = OP_REJECT;
              state_d = ST_FIN;
            end else if (sts_i.alloc_none) begin
              op_o    = OP_OOM;
              state_d = ST_FIN;
            end else begin
              op_o    = OP_A_FIND;
              state_d = ST_A_SPLIT;
            end
          end
          ACT_FREE: begin
            if (sts_i.ord_bad || sts_i.free_bad) begin
              op_o    = OP_REJECT;
              state_d = ST_FIN;
            end else begin
              op_o    = OP_F_RD;
              state_d = ST_F_CHK;
            end
          end
          default: begin
            if (sts_i.rng_bad) begin
              op_o    = OP_REJECT;
              state_d = ST_FIN;
            end else begin
              state_d = ST_R_LOOP;
            end
          end
        endcase
      end
      ST_A_SPLIT: begin
        if (sts_i.split_done) begin
          op_o    = OP_A_POP_RD;
          state_d = ST_A_POP_W;
        end else begin
          op_o    = OP_A_SPLIT_RD;
          state_d = ST_A_SPLIT_W;
        end
      end
      ST_A_SPLIT_W: begin
        op_o    = OP_A_SPLIT_LO;
        state_d = ST_A_SPLIT_HI;
      end
      ST_A_SPLIT_HI: begin
        op_o    = OP_A_SPLIT_HI;
        state_d = ST_A_SPLIT;
      end
      ST_A_POP_W: begin
        op_o    = OP_A_POP_WR;
        state_d = ST_FIN;
      end
      ST_F_CHK: begin
        if (sts_i.mark_resv) begin
          op_o    = OP_REJECT;
          state_d = ST_FIN;
        end else begin
          op_o    = OP_F_PUSH;
          state_d = ST_M_TOP;
        end
      end
      ST_M_TOP: begin
        if (sts_i.top) begin
          state_d = ST_M_RET;
        end else begin
          op_o    = OP_M_RD;
          state_d = ST_M_CHK;
        end
      end
      ST_M_CHK: begin
        if (!sts_i.mark_free || !sts_i.mate_match) begin
          state_d = ST_M_RET;
        end else begin
          op_o     = OP_RM_SELF;
          second_d = 1'b0;
          state_d  = ST_RM_HEAD;
        end
      end
      ST_RM_HEAD: begin
        if (sts_i.wk_nil) begin
          state_d = ST_RM_END;
        end else if (sts_i.wk_hit) begin
          op_o    = OP_RM_HRD;
          state_d = ST_RM_HW;
        end else begin
          op_o    = OP_RM_WRD;
          state_d = ST_RM_WW;
        end
      end
      ST_RM_HW: begin
        op_o    = OP_RM_HWR;
        state_d = ST_RM_END;
      end
      ST_RM_WALK: begin
        if (sts_i.wk_nil) begin
          state_d = ST_RM_END;
        end else begin
          op_o    = OP_RM_WRD;
          state_d = ST_RM_WW;
        end
      end
      ST_RM_WW: begin
        if (sts_i.link_hit) begin
          op_o    = OP_RM_FRD;
          state_d = ST_RM_FW;
        end else if (sts_i.steps_max) begin
          state_d = ST_RM_END;
        end else begin
          op_o    = OP_RM_STEP;
          state_d = ST_RM_WALK;
        end
      end
      ST_RM_FW: begin
        op_o    = OP_RM_FWR;
        state_d = ST_RM_END;
      end
      ST_RM_END: begin
        if (!second_q) begin
          op_o     = OP_RM_MATE;
          second_d = 1'b1;
          state_d  = ST_RM_HEAD;
        end else begin
          state_d = ST_M_HI;
        end
      end
      ST_M_HI: begin
        op_o    = OP_M_HRD;
        state_d = ST_M_HW;
      end
      ST_M_HW: begin
        op_o    = OP_M_HWR;
        state_d = ST_M_LO;
      end
      ST_M_LO: begin
        op_o    = OP_M_LRD;
        state_d = ST_M_LW;
      end
      ST_M_LW: begin
        op_o    = OP_M_LWR;
        state_d = ST_M_TOP;
      end
      ST_M_RET: begin
        if (sts_i.act == ACT_REL) begin
          op_o    = OP_R_SKIP;
          state_d = ST_R_LOOP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_R_LOOP: begin
        if (sts_i.rng_end) begin
          state_d = ST_FIN;
        end else begin
          op_o    = OP_R_RD;
          state_d = ST_R_W;
        end
      end
      ST_R_W: begin
        if (sts_i.act == ACT_RESV) begin
          op_o    = OP_R_RESV;
          state_d = ST_R_LOOP;
        end else if (sts_i.mark_resv) begin
          op_o    = OP_R_SKIP;
          state_d = ST_R_LOOP;
        end else begin
          op_o    = OP_R_PUSH;
          state_d = ST_M_TOP;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          op_o    = OP_FIN;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // an accepted request is always dispatched next
  a_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_DISP)
    else $error("request not dispatched");

  // merge writes only after both removals
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_M_HI |-> second_q)
    else $error("merge before mate removal");

  // no request taken during the clearing pass
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> op_o == OP_CLEAR)
    else $error("clearing pass interrupted");

endmodule

[src/buddy_page_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Buddy page allocator, orders 0 to 10, LIFO free list per order, with
// allocate, free, reserve range and release range requests.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  cfg      | cfg_we_i                | cfg_index_i, cfg_wdata_i
//  in       | in_valid_i / in_ready_o | action, block_order, address, pages
//  out      | out_valid_o/out_ready_i | status, block_address, used, total
//
//  One request at a time. Allocate splits a larger block as often as needed,
//  then pops. Free pushes the block, then merges, walking the list per removal.
//  Range walks page by page: reserved and skipped pages are marked or passed,
//  and each released page is freed and also pays the merge cost.
//  After reset a clearing pass zeroes the marks of all 65536 pages; no
//  request is taken until it ends. A waiting result stalls only the last step.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [bpa_pkg::BASE_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [bpa_pkg::ORD_W-1:0]  block_order_i,
  input  logic [bpa_pkg::ADDR_W-1:0] address_i,
  input  logic [bpa_pkg::RNG_W-1:0]  first_page_i,
  input  logic [bpa_pkg::RNG_W-1:0]  end_page_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [bpa_pkg::ADDR_W-1:0] block_address_o,
  output logic [bpa_pkg::CNT_W-1:0]  used_pages_o,
  output logic [bpa_pkg::CNT_W-1:0]  total_pages_o
);
  import bpa_pkg::*;

  sts_t sts;
  op_e  op;

  bpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i (sts),
    .op_o  (op)
  );

  bpa_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .action_i,
    .block_order_i,
    .address_i,
    .first_page_i,
    .end_page_i,
    .op_i  (op),
    .sts_o (sts),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .block_address_o,
    .used_pages_o,
    .total_pages_o
  );

endmodule
